[design/tcf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the toroid coil field unit.
// No dependencies; used by the top unit toroid_coil_field_at_point_unit.
package tcf_pkg;

   localparam int COORD_W    = 32;  // coordinate width, Q.10 mm
   localparam int FIELD_W    = 32;  // field width, Q.24
   localparam int FRAC_BITS  = 16;  // enclosed fraction, Q.16
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int LEN_W      = 31;  // geometry register width

   // register indexes (byte address / 4)
   localparam logic [2:0] CSR_IDX_HALF_HEIGHT = 3'd0;
   localparam logic [2:0] CSR_IDX_RADIUS_MIN  = 3'd1;
   localparam logic [2:0] CSR_IDX_RADIUS_MAX  = 3'd2;
   localparam logic [2:0] CSR_IDX_CORNER      = 3'd3;
   localparam logic [2:0] CSR_IDX_THICKNESS   = 3'd4;
   localparam logic [2:0] CSR_IDX_COEFF       = 3'd5;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } req_beat_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] field_x;
      logic signed [FIELD_W-1:0] field_y;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_FULL,
      MODE_RAMP,
      MODE_CORNER
   } mode_type;

   // point data carried down the pipe
   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic        sx;
      logic        sy;
      logic [63:0] rho2;
   } pt_type;

   typedef struct packed {
      pt_type      pt;
      logic [31:0] az;
   } sqa_side_type;

   typedef struct packed {
      pt_type      pt;
      mode_type    mode;
      logic [31:0] gap;
   } cls_type;

   typedef struct packed {
      pt_type   pt;
      mode_type mode;
   } ramp_side_type;

   typedef struct packed {
      logic neg;
      logic ovf;
      logic zero;
   } fld_side_type;

endpackage

[design/tcf_sqrt_pipe.sv]
`timescale 1ns / 1ps
// Pipelined 64-bit integer square root, one root bit per stage (32 stages).
// Uses no package items; sideband rides along with each beat.
module tcf_sqrt_pipe #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [63:0]       in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [31:0]       out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NSTG = 32;

   logic              vld_ff  [1:NSTG];
   logic [63:0]       rad_ff  [1:NSTG];
   logic [33:0]       rem_ff  [1:NSTG];
   logic [31:0]       root_ff [1:NSTG];
   logic [SIDE_W-1:0] side_ff [1:NSTG];

   for (genvar s = 1; s <= NSTG; s++) begin : g_stg
      logic              p_vld;
      logic [63:0]       p_rad;
      logic [33:0]       p_rem;
      logic [31:0]       p_root;
      logic [SIDE_W-1:0] p_side;
      logic [35:0]       trial_rem;
      logic [35:0]       trial_sub;
      logic              ge;
      logic [33:0]       rem_in;
      logic [31:0]       root_in;

      if (s == 1) begin : g_first
         assign p_vld  = in_vld;
         assign p_rad  = in_rad;
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_side = in_side;
      end else begin : g_next
         assign p_vld  = vld_ff[s-1];
         assign p_rad  = rad_ff[s-1];
         assign p_rem  = rem_ff[s-1];
         assign p_root = root_ff[s-1];
         assign p_side = side_ff[s-1];
      end

      always_comb begin
         trial_rem = {p_rem, p_rad[63:62]};
         trial_sub = {2'b00, p_root, 2'b01};
         ge        = trial_rem >= trial_sub;
         rem_in    = ge ? 34'(trial_rem - trial_sub) : 34'(trial_rem);
         root_in   = {p_root[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= {p_rad[61:0], 2'b00};
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= p_side;
         end
      end
   end

   assign out_vld  = vld_ff[NSTG];
   assign out_root = root_ff[NSTG];
   assign out_side = side_ff[NSTG];

endmodule

[design/tcf_div_pipe.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Caller supplies a starting remainder below the divisor. No package use.
module tcf_div_pipe #(
   parameter int DEN_W  = 32,
   parameter int Q_W    = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [Q_W-1:0]    in_bits,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [Q_W-1:0]    out_q,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [1:Q_W];
   logic [DEN_W-1:0]  rem_ff  [1:Q_W];
   logic [Q_W-1:0]    bits_ff [1:Q_W];
   logic [DEN_W-1:0]  den_ff  [1:Q_W];
   logic [Q_W-1:0]    q_ff    [1:Q_W];
   logic [SIDE_W-1:0] side_ff [1:Q_W];

   for (genvar s = 1; s <= Q_W; s++) begin : g_stg
      logic              p_vld;
      logic [DEN_W-1:0]  p_rem;
      logic [Q_W-1:0]    p_bits;
      logic [DEN_W-1:0]  p_den;
      logic [Q_W-1:0]    p_q;
      logic [SIDE_W-1:0] p_side;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;

      if (s == 1) begin : g_first
         assign p_vld  = in_vld;
         assign p_rem  = in_rem;
         assign p_bits = in_bits;
         assign p_den  = in_den;
         assign p_q    = '0;
         assign p_side = in_side;
      end else begin : g_next
         assign p_vld  = vld_ff[s-1];
         assign p_rem  = rem_ff[s-1];
         assign p_bits = bits_ff[s-1];
         assign p_den  = den_ff[s-1];
         assign p_q    = q_ff[s-1];
         assign p_side = side_ff[s-1];
      end

      always_comb begin
         trial  = {p_rem, p_bits[Q_W-1]};
         ge     = trial >= {1'b0, p_den};
         rem_in = ge ? DEN_W'(trial - {1'b0, p_den}) : DEN_W'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            bits_ff[s] <= {p_bits[Q_W-2:0], 1'b0};
            den_ff[s]  <= p_den;
            q_ff[s]    <= {p_q[Q_W-2:0], ge};
            side_ff[s] <= p_side;
         end
      end
   end

   assign out_vld  = vld_ff[Q_W];
   assign out_q    = q_ff[Q_W];
   assign out_side = side_ff[Q_W];

endmodule

[design/toroid_coil_field_at_point_unit.sv]
`timescale 1ns / 1ps
// Toroid coil field unit: azimuthal field of a rounded-rectangle toroid at a point.
// 123 register stages, request to response; one beat per cycle unless output stalls.
// Depth is set by two 32-stage square roots, a 16-stage fraction divider and
// two parallel 32-stage field dividers. Synchronous active-high reset clears
// all valid bits and loads register defaults (thickness 1, others 0).
// Depends on tcf_pkg, tcf_sqrt_pipe, tcf_div_pipe.
module toroid_coil_field_at_point_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tcf_pkg::req_beat_type                 req_data,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tcf_pkg::rsp_beat_type                 rsp_data,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tcf_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [tcf_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int FW = tcf_pkg::FIELD_W;

   // whole pipe moves together; it holds only when the output beat is stalled
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- registers ----------------
   logic [tcf_pkg::LEN_W-1:0] reg_h_ff, reg_rmin_ff, reg_rmax_ff, reg_c_ff, reg_d_ff;
   logic [31:0]               reg_k_ff;
   logic                      csr_wr;
   logic [2:0]                csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_h_ff    <= '0;
         reg_rmin_ff <= '0;
         reg_rmax_ff <= '0;
         reg_c_ff    <= '0;
         reg_d_ff    <= 31'd1;
         reg_k_ff    <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            tcf_pkg::CSR_IDX_HALF_HEIGHT: reg_h_ff    <= csr_pwdata[30:0];
            tcf_pkg::CSR_IDX_RADIUS_MIN:  reg_rmin_ff <= csr_pwdata[30:0];
            tcf_pkg::CSR_IDX_RADIUS_MAX:  reg_rmax_ff <= csr_pwdata[30:0];
            tcf_pkg::CSR_IDX_CORNER:      reg_c_ff    <= csr_pwdata[30:0];
            tcf_pkg::CSR_IDX_THICKNESS:   reg_d_ff    <= csr_pwdata[30:0];
            tcf_pkg::CSR_IDX_COEFF:       reg_k_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         tcf_pkg::CSR_IDX_HALF_HEIGHT: csr_prdata = {1'b0, reg_h_ff};
         tcf_pkg::CSR_IDX_RADIUS_MIN:  csr_prdata = {1'b0, reg_rmin_ff};
         tcf_pkg::CSR_IDX_RADIUS_MAX:  csr_prdata = {1'b0, reg_rmax_ff};
         tcf_pkg::CSR_IDX_CORNER:      csr_prdata = {1'b0, reg_c_ff};
         tcf_pkg::CSR_IDX_THICKNESS:   csr_prdata = {1'b0, reg_d_ff};
         tcf_pkg::CSR_IDX_COEFF:       csr_prdata = reg_k_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   // zero thickness acts as one
   logic [tcf_pkg::LEN_W-1:0] d_eff;
   assign d_eff = (reg_d_ff == '0) ? 31'd1 : reg_d_ff;

   // ---------------- stage A: magnitudes ----------------
   logic        a_vld_ff;
   logic [31:0] a_ax_ff, a_ay_ff, a_az_ff;
   logic        a_sx_ff, a_sy_ff;
   logic [31:0] a_ax_in, a_ay_in, a_az_in;

   always_comb begin
      a_ax_in = req_data.pos_x[31] ? (~req_data.pos_x + 32'd1) : req_data.pos_x;
      a_ay_in = req_data.pos_y[31] ? (~req_data.pos_y + 32'd1) : req_data.pos_y;
      a_az_in = req_data.pos_z[31] ? (~req_data.pos_z + 32'd1) : req_data.pos_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ax_ff <= a_ax_in;
         a_ay_ff <= a_ay_in;
         a_az_ff <= a_az_in;
         a_sx_ff <= req_data.pos_x[31];
         a_sy_ff <= req_data.pos_y[31];
      end
   end

   // ---------------- stage B: squares ----------------
   logic        b_vld_ff;
   logic [63:0] b_sqx_ff, b_sqy_ff;
   logic [31:0] b_ax_ff, b_ay_ff, b_az_ff;
   logic        b_sx_ff, b_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_sqx_ff <= a_ax_ff * a_ax_ff;
         b_sqy_ff <= a_ay_ff * a_ay_ff;
         b_ax_ff  <= a_ax_ff;
         b_ay_ff  <= a_ay_ff;
         b_az_ff  <= a_az_ff;
         b_sx_ff  <= a_sx_ff;
         b_sy_ff  <= a_sy_ff;
      end
   end

   // ---------------- stage C: rho squared ----------------
   logic                  c_vld_ff;
   tcf_pkg::sqa_side_type c_side_ff, c_side_in;

   always_comb begin
      c_side_in.pt.ax   = b_ax_ff;
      c_side_in.pt.ay   = b_ay_ff;
      c_side_in.pt.sx   = b_sx_ff;
      c_side_in.pt.sy   = b_sy_ff;
      c_side_in.pt.rho2 = b_sqx_ff + b_sqy_ff;
      c_side_in.az      = b_az_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_side_ff <= c_side_in;
      end
   end

   // ---------------- rho = floor(sqrt(rho2)) ----------------
   logic                  sqa_vld;
   logic [31:0]           sqa_root;
   tcf_pkg::sqa_side_type sqa_side;

   tcf_sqrt_pipe #(
      .SIDE_W($bits(tcf_pkg::sqa_side_type))
   ) u_sqrt_rho (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (c_vld_ff),
      .in_rad  (c_side_ff.pt.rho2),
      .in_side (c_side_ff),
      .out_vld (sqa_vld),
      .out_root(sqa_root),
      .out_side(sqa_side)
   );

   // ---------------- stage D: region sort ----------------
   // 35-bit signed keeps all bound sums and differences exact
   logic signed [34:0] rho_s, az_s, z1, z2, r1lo, r2lo, r1hi, r2hi, c_s, d_s;
   logic signed [34:0] dz_s, dr_s;
   tcf_pkg::cls_type   d_cls_in, d_cls_ff;
   logic [31:0]        d_dz_ff, d_dr_ff;
   logic               d_vld_ff;

   always_comb begin
      rho_s = $signed({3'b000, sqa_root});
      az_s  = $signed({3'b000, sqa_side.az});
      c_s   = $signed({4'b0000, reg_c_ff});
      d_s   = $signed({4'b0000, d_eff});
      z1    = $signed({4'b0000, reg_h_ff});
      z2    = z1 + c_s;
      r1lo  = $signed({4'b0000, reg_rmin_ff});
      r2lo  = r1lo - c_s;
      r1hi  = $signed({4'b0000, reg_rmax_ff});
      r2hi  = r1hi + c_s;
      dz_s  = az_s - z1;
      dr_s  = (rho_s <= r1lo) ? (r1lo - rho_s) : (rho_s - r1hi);

      d_cls_in.pt   = sqa_side.pt;
      d_cls_in.mode = tcf_pkg::MODE_FULL;
      d_cls_in.gap  = '0;
      if (az_s >= z2 || rho_s <= r2lo || rho_s >= r2hi) begin
         d_cls_in.mode = tcf_pkg::MODE_ZERO;
      end else if (az_s < z1 && rho_s >= r1lo && rho_s <= r1hi) begin
         d_cls_in.mode = tcf_pkg::MODE_FULL;
      end else if (az_s < z1) begin
         // left or right straight edge
         if (rho_s <= r2lo + d_s) begin
            d_cls_in.mode = tcf_pkg::MODE_RAMP;
            d_cls_in.gap  = 32'(rho_s - r2lo);
         end else if (rho_s >= r2hi - d_s) begin
            d_cls_in.mode = tcf_pkg::MODE_RAMP;
            d_cls_in.gap  = 32'(r2hi - rho_s);
         end
      end else if (rho_s >= r1lo && rho_s <= r1hi) begin
         // top edge
         if (az_s >= z2 - d_s) begin
            d_cls_in.mode = tcf_pkg::MODE_RAMP;
            d_cls_in.gap  = 32'(z2 - az_s);
         end
      end else begin
         d_cls_in.mode = tcf_pkg::MODE_CORNER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= sqa_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_cls_ff <= d_cls_in;
         d_dz_ff  <= 32'(dz_s);
         d_dr_ff  <= 32'(dr_s);
      end
   end

   // ---------------- stages E, F: corner distance squared ----------------
   logic             e_vld_ff, f_vld_ff;
   logic [63:0]      e_sqz_ff, e_sqr_ff, f_sum_ff;
   tcf_pkg::cls_type e_cls_ff, f_cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_sqz_ff <= d_dz_ff * d_dz_ff;
         e_sqr_ff <= d_dr_ff * d_dr_ff;
         e_cls_ff <= d_cls_ff;
         f_sum_ff <= e_sqz_ff + e_sqr_ff;
         f_cls_ff <= e_cls_ff;
      end
   end

   logic             sqb_vld;
   logic [31:0]      sqb_root;
   tcf_pkg::cls_type sqb_cls;

   tcf_sqrt_pipe #(
      .SIDE_W($bits(tcf_pkg::cls_type))
   ) u_sqrt_corner (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (f_vld_ff),
      .in_rad  (f_sum_ff),
      .in_side (f_cls_ff),
      .out_vld (sqb_vld),
      .out_root(sqb_root),
      .out_side(sqb_cls)
   );

   // ---------------- stage G: resolve corner, ramp saturation ----------------
   logic                   g_vld_ff;
   tcf_pkg::ramp_side_type g_side_ff, g_side_in;
   logic [31:0]            g_gap_ff, g_gap_in;
   logic signed [34:0]     cr_s;

   always_comb begin
      cr_s           = $signed({3'b000, sqb_root});
      g_side_in.pt   = sqb_cls.pt;
      g_side_in.mode = sqb_cls.mode;
      g_gap_in       = sqb_cls.gap;
      if (sqb_cls.mode == tcf_pkg::MODE_CORNER) begin
         if (cr_s < c_s - d_s) begin
            g_side_in.mode = tcf_pkg::MODE_FULL;
         end else if (cr_s < c_s) begin
            g_side_in.mode = tcf_pkg::MODE_RAMP;
            g_gap_in       = 32'(c_s - cr_s);
         end else begin
            g_side_in.mode = tcf_pkg::MODE_ZERO;
         end
      end
      // a ramp distance of at least the thickness is full current
      if (g_side_in.mode == tcf_pkg::MODE_RAMP && g_gap_in >= {1'b0, d_eff}) begin
         g_side_in.mode = tcf_pkg::MODE_FULL;
      end
      if (g_side_in.mode != tcf_pkg::MODE_RAMP) begin
         g_gap_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= sqb_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_side_ff <= g_side_in;
         g_gap_ff  <= g_gap_in;
      end
   end

   // fraction = gap * 2^16 / d, gap below d
   logic                           rdv_vld;
   logic [tcf_pkg::FRAC_BITS-1:0]  rdv_q;
   tcf_pkg::ramp_side_type         rdv_side;

   tcf_div_pipe #(
      .DEN_W (32),
      .Q_W   (tcf_pkg::FRAC_BITS),
      .SIDE_W($bits(tcf_pkg::ramp_side_type))
   ) u_div_frac (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (g_vld_ff),
      .in_rem  (g_gap_ff),
      .in_bits ('0),
      .in_den  ({1'b0, d_eff}),
      .in_side (g_side_ff),
      .out_vld (rdv_vld),
      .out_q   (rdv_q),
      .out_side(rdv_side)
   );

   // ---------------- stage H: k * f ----------------
   logic                         h_vld_ff;
   logic [48:0]                  h_qmag_ff;
   tcf_pkg::pt_type              h_pt_ff;
   logic                         h_kneg_ff;
   logic [tcf_pkg::FRAC_BITS:0]  h_frac;
   logic [31:0]                  k_abs;

   always_comb begin
      k_abs = reg_k_ff[31] ? (~reg_k_ff + 32'd1) : reg_k_ff;
      case (rdv_side.mode)
         tcf_pkg::MODE_FULL: h_frac = {1'b1, {tcf_pkg::FRAC_BITS{1'b0}}};
         tcf_pkg::MODE_RAMP: h_frac = {1'b0, rdv_q};
         default:            h_frac = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= rdv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_qmag_ff <= k_abs * h_frac;
         h_pt_ff   <= rdv_side.pt;
         h_kneg_ff <= reg_k_ff[31];
      end
   end

   // ---------------- stage I: partial products ----------------
   logic            i_vld_ff;
   logic [63:0]     i_lox_ff, i_loy_ff;
   logic [48:0]     i_hix_ff, i_hiy_ff;
   tcf_pkg::pt_type i_pt_ff;
   logic            i_kneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else if (adv) begin
         i_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // field_x uses |y|, field_y uses |x|
         i_lox_ff  <= h_qmag_ff[31:0] * h_pt_ff.ay;
         i_hix_ff  <= h_qmag_ff[48:32] * h_pt_ff.ay;
         i_loy_ff  <= h_qmag_ff[31:0] * h_pt_ff.ax;
         i_hiy_ff  <= h_qmag_ff[48:32] * h_pt_ff.ax;
         i_pt_ff   <= h_pt_ff;
         i_kneg_ff <= h_kneg_ff;
      end
   end

   // ---------------- stage J: numerator and overflow check ----------------
   logic                  j_vld_ff;
   logic [63:0]           j_remx_ff, j_remy_ff, j_remx_in, j_remy_in;
   logic [FW-1:0]         j_bitx_ff, j_bity_ff;
   logic [63:0]           j_den_ff;
   tcf_pkg::fld_side_type j_sx_ff, j_sy_ff, j_sx_in, j_sy_in;
   logic [80:0]           prod_x, prod_y;
   logic [74:0]           num_x, num_y;
   logic [63:0]           high_x, high_y;

   always_comb begin
      prod_x = {17'b0, i_lox_ff} + ({32'b0, i_hix_ff} << 32);
      prod_y = {17'b0, i_loy_ff} + ({32'b0, i_hiy_ff} << 32);
      num_x  = prod_x[80:6];
      num_y  = prod_y[80:6];
      high_x = {21'b0, num_x[74:FW]};
      high_y = {21'b0, num_y[74:FW]};

      j_sx_in.ovf  = high_x >= i_pt_ff.rho2;
      j_sy_in.ovf  = high_y >= i_pt_ff.rho2;
      j_sx_in.neg  = i_kneg_ff ^ i_pt_ff.sy;
      j_sy_in.neg  = ~(i_kneg_ff ^ i_pt_ff.sx);
      j_sx_in.zero = i_pt_ff.rho2 == '0;
      j_sy_in.zero = i_pt_ff.rho2 == '0;
      j_remx_in    = j_sx_in.ovf ? '0 : high_x;
      j_remy_in    = j_sy_in.ovf ? '0 : high_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
      end else if (adv) begin
         j_vld_ff <= i_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         j_remx_ff <= j_remx_in;
         j_remy_ff <= j_remy_in;
         j_bitx_ff <= num_x[FW-1:0];
         j_bity_ff <= num_y[FW-1:0];
         j_den_ff  <= i_pt_ff.rho2;
         j_sx_ff   <= j_sx_in;
         j_sy_ff   <= j_sy_in;
      end
   end

   // ---------------- field dividers ----------------
   logic                  fdx_vld, fdy_vld;
   logic [FW-1:0]         fdx_q, fdy_q;
   tcf_pkg::fld_side_type fdx_side, fdy_side;

   tcf_div_pipe #(
      .DEN_W (64),
      .Q_W   (FW),
      .SIDE_W($bits(tcf_pkg::fld_side_type))
   ) u_div_fx (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (j_vld_ff),
      .in_rem  (j_remx_ff),
      .in_bits (j_bitx_ff),
      .in_den  (j_den_ff),
      .in_side (j_sx_ff),
      .out_vld (fdx_vld),
      .out_q   (fdx_q),
      .out_side(fdx_side)
   );

   tcf_div_pipe #(
      .DEN_W (64),
      .Q_W   (FW),
      .SIDE_W($bits(tcf_pkg::fld_side_type))
   ) u_div_fy (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (j_vld_ff),
      .in_rem  (j_remy_ff),
      .in_bits (j_bity_ff),
      .in_den  (j_den_ff),
      .in_side (j_sy_ff),
      .out_vld (fdy_vld),
      .out_q   (fdy_q),
      .out_side(fdy_side)
   );

   // ---------------- stage K: saturate, sign, output register ----------------
   logic                  rsp_valid_ff;
   tcf_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;
   logic [FW-1:0]         lim_x, lim_y, sat_x, sat_y;

   always_comb begin
      lim_x = fdx_side.neg ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
      lim_y = fdy_side.neg ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
      sat_x = (fdx_side.ovf || fdx_q > lim_x) ? lim_x : fdx_q;
      sat_y = (fdy_side.ovf || fdy_q > lim_y) ? lim_y : fdy_q;
      rsp_data_in.field_x = fdx_side.neg ? (~sat_x + 1'b1) : sat_x;
      rsp_data_in.field_y = fdy_side.neg ? (~sat_y + 1'b1) : sat_y;
      // on the axis both components are zero
      if (fdx_side.zero) begin
         rsp_data_in.field_x = '0;
      end
      if (fdy_side.zero) begin
         rsp_data_in.field_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fdx_vld && fdy_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
